// ===== sv/sbnt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse bitmap node table package
// Sizes, operation and status codes, and the request and response payloads.
// ----------------------------------------------------------------------------
package sbnt_pkg;

  localparam int NODE_COUNT  = 16;
  localparam int INDEX_BITS  = 16;
  localparam int WORD_BITS   = 64;
  localparam int OFFSET_BITS = $clog2(WORD_BITS);
  localparam int BUCKET_BITS = INDEX_BITS - OFFSET_BITS;
  localparam int MARK_BITS   = INDEX_BITS + 1;
  localparam int COUNT_BITS  = $clog2(NODE_COUNT + 1);

  // Operation codes. The fourth code behaves as a read.
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [1:0]            op;
    logic [INDEX_BITS-1:0] bit_index;
  } req_t;

  typedef struct packed {
    logic                  bit_value;
    logic                  status;
    logic [MARK_BITS-1:0]  high_mark;
    logic [COUNT_BITS-1:0] nodes_in_use;
  } rsp_t;

endpackage

// ===== sv/sparse_bitmap_node_table_top.sv =====
// ----------------------------------------------------------------------------
// Sparse bitmap node table
// Usage:
//   The request channel (req_valid, req_stall, req) carries one operation per
//   transaction: read, set or clear of one bit of a sparse bitmap. The bitmap
//   is kept as a table of nodes, each covering one 64-bit aligned bucket.
//   Every request gives exactly one response transaction on the rsp channel
//   with the bit value, a table-full status, the high mark and node count.
//   A request is captured in an input register; when it fires (the response
//   register is empty or not stalled), the node table is searched and
//   updated and the response register is loaded.
//   Throughput is one request per cycle while the receiver does not stall:
//   the whole node table sits in flip-flops, so a parallel bucket compare and
//   a word update finish as the request fires and the next request sees the
//   updated table. When the receiver stalls, the response holds, the input
//   register holds one more request, and req_stall then rises until the response drains.
//   Reset (rst, synchronous) frees all nodes, zeros the high mark and
//   empties both registers. No clearing pass is needed.
// ----------------------------------------------------------------------------
module sparse_bitmap_node_table_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sbnt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sbnt_pkg::rsp_t rsp
);
  import sbnt_pkg::*;

  // Input register.
  logic req_q_valid;
  req_t req_q;

  // Node table.
  logic [BUCKET_BITS-1:0] node_bucket [NODE_COUNT];
  logic [WORD_BITS-1:0]   node_word   [NODE_COUNT];
  logic [NODE_COUNT-1:0]  node_used;
  logic [MARK_BITS-1:0]   high_mark;
  logic [COUNT_BITS-1:0]  count;

  logic fire;
  logic accept;

  logic [BUCKET_BITS-1:0] bucket;
  logic [OFFSET_BITS-1:0] offset;
  logic [WORD_BITS-1:0]   mask;
  logic [NODE_COUNT-1:0]  match;
  logic [NODE_COUNT-1:0]  free_first;
  logic [NODE_COUNT-1:0]  wr_en;
  logic                   hit;
  logic                   full;
  logic [WORD_BITS-1:0]   slot_word;
  logic [WORD_BITS-1:0]   wr_word;
  logic                   is_set;
  logic                   is_clear;
  logic                   do_alloc;
  logic                   do_free;
  logic [MARK_BITS-1:0]   ceil_mark;
  logic [MARK_BITS-1:0]   high_mark_next;
  logic [COUNT_BITS-1:0]  count_next;
  rsp_t                   rsp_next;

  assign fire      = req_q_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = req_q_valid && !fire;
  assign accept    = req_valid && !req_stall;

  assign bucket = req_q.bit_index[INDEX_BITS-1:OFFSET_BITS];
  assign offset = req_q.bit_index[OFFSET_BITS-1:0];
  assign mask   = {{(WORD_BITS-1){1'b0}}, 1'b1} << offset;

  always_comb begin
    slot_word = '0;
    for (int i = 0; i < NODE_COUNT; i++) begin
      match[i]  = node_used[i] && (node_bucket[i] == bucket);
      slot_word = slot_word | (match[i] ? node_word[i] : '0);
    end
  end

  assign hit        = |match;
  assign full       = &node_used;
  // Lowest free node as a one-hot vector.
  assign free_first = ~node_used & (node_used + NODE_COUNT'(1));

  assign is_set   = (req_q.op == OP_SET);
  assign is_clear = (req_q.op == OP_CLEAR);
  assign do_alloc = is_set && !hit && !full;
  assign wr_word  = is_set ? (hit ? (slot_word | mask) : mask) : (slot_word & ~mask);
  assign do_free  = is_clear && hit && (wr_word == '0);
  assign ceil_mark = {({1'b0, bucket} + (BUCKET_BITS+1)'(1)), {OFFSET_BITS{1'b0}}};

  always_comb begin
    for (int i = 0; i < NODE_COUNT; i++) begin
      wr_en[i] = fire && ((is_set && (hit ? match[i] : (!full && free_first[i])))
                          || (is_clear && match[i]));
    end
  end

  always_comb begin
    high_mark_next = high_mark;
    count_next     = count;
    rsp_next.bit_value = 1'b0;
    rsp_next.status    = STATUS_DONE;
    if (is_set) begin
      if (hit || !full) begin
        rsp_next.bit_value = 1'b1;
        if (ceil_mark > high_mark) begin
          high_mark_next = ceil_mark;
        end
      end else begin
        rsp_next.status = STATUS_FULL;
      end
      if (do_alloc) begin
        count_next = count + COUNT_BITS'(1);
      end
    end else if (is_clear) begin
      if (do_free) begin
        count_next = count - COUNT_BITS'(1);
        if (count == COUNT_BITS'(1)) begin
          high_mark_next = '0;
        end
      end
    end else begin
      rsp_next.bit_value = slot_word[offset];
    end
    rsp_next.high_mark    = high_mark_next;
    rsp_next.nodes_in_use = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
      rsp_valid   <= 1'b0;
      node_used   <= '0;
      high_mark   <= '0;
      count       <= '0;
    end else begin
      if (accept) begin
        req_q_valid <= 1'b1;
      end else if (fire) begin
        req_q_valid <= 1'b0;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
        high_mark <= high_mark_next;
        count     <= count_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      for (int i = 0; i < NODE_COUNT; i++) begin
        if (wr_en[i] && do_alloc) begin
          node_used[i] <= 1'b1;
        end else if (wr_en[i] && do_free) begin
          node_used[i] <= 1'b0;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (fire) begin
      rsp <= rsp_next;
    end
    for (int i = 0; i < NODE_COUNT; i++) begin
      if (wr_en[i]) begin
        node_word[i] <= wr_word;
        if (do_alloc) begin
          node_bucket[i] <= bucket;
        end
      end
    end
  end

  // The node count always agrees with the occupied flags.
  a_count_matches_used: assert property (@(posedge clk) disable iff (rst)
    int'(count) == $countones(node_used))
    else $error("node count differs from occupied node flags");

  // The high mark is zero exactly when no node is occupied.
  a_mark_zero_when_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) == (high_mark == '0))
    else $error("high mark and node occupancy disagree");

  // A bucket is never held by two occupied nodes.
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("bucket held by more than one node");

  // A refused set is only reported when the table is full.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == STATUS_FULL)) |-> (count == COUNT_BITS'(NODE_COUNT)))
    else $error("table-full status with free nodes left");

endmodule
